### rtl/mrp_pkg.sv
package mrp_pkg;

	typedef enum logic [2:0] {
		PH_HEAD   = 3'd0,
		PH_DIGEST = 3'd1,
		PH_RLEN   = 3'd2,
		PH_RBODY  = 3'd3,
		PH_PLEN   = 3'd4,
		PH_PBODY  = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_BAD_VER   = 3'd2,
		ST_BAD_PROF  = 3'd3,
		ST_BAD_FLAG  = 3'd4,
		ST_ZERO_LEN  = 3'd5
	} status_t;

	// configuration register indexes
	localparam logic [2:0] REG_VERSION    = 3'd0;
	localparam logic [2:0] REG_SHORT_PROF = 3'd1;
	localparam logic [2:0] REG_LONG_PROF  = 3'd2;
	localparam logic [2:0] REG_DIG_MASK   = 3'd3;
	localparam logic [2:0] REG_RES_MASK   = 3'd4;
	localparam logic [2:0] REG_POS_MASK   = 3'd5;

	localparam logic [4:0] HEAD_LAST  = 5'd18;
	localparam logic [4:0] HEAD_BYTES = 5'd19;
	localparam logic [4:0] CHUNK_END  = 5'd5;
	localparam logic [4:0] FILE_END   = 5'd13;
	localparam logic [4:0] TOTAL_END  = 5'd15;
	localparam logic [4:0] DATA_END   = 5'd17;

	localparam logic [15:0] SHORT_DIGEST = 16'd32;
	localparam logic [15:0] LONG_DIGEST  = 16'd64;

	typedef struct packed {
		logic [7:0] version_code;
		logic [7:0] short_profile_code;
		logic [7:0] long_profile_code;
		logic [7:0] digest_flag_mask;
		logic [7:0] restriction_flag_mask;
		logic [7:0] possession_flag_mask;
	} cfg_t;

	// one classified byte as passed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       ver_match;
		logic       prof_short;
		logic       prof_long;
		logic       flag_unknown;
		logic       flag_digest;
		logic       flag_restr;
		logic       flag_poss;
	} cls_item_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  profile_code;
		logic [31:0] chunk_bytes;
		logic [63:0] file_length;
		logic [15:0] total_shards;
		logic [15:0] data_shards;
		logic [7:0]  tail_flags;
		logic [15:0] restriction_length;
		logic [15:0] possession_length;
		logic [17:0] consumed_bytes;
	} result_t;

endpackage

### rtl/mrp_front.sv
module mrp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  mrp_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               item_valid,
	input  logic               item_ready,
	output mrp_pkg::cls_item_t item
);

	logic               valid_s1;
	mrp_pkg::cls_item_t item_s1;
	mrp_pkg::cls_item_t cls;
	logic [7:0]         known;

	// every byte gets compared against all codes; the back picks what its phase needs
	always_comb begin
		known            = cfg.digest_flag_mask | cfg.restriction_flag_mask
			| cfg.possession_flag_mask;
		cls.data_byte    = in_byte;
		cls.last         = in_last;
		cls.ver_match    = (in_byte == cfg.version_code);
		cls.prof_short   = (in_byte == cfg.short_profile_code);
		cls.prof_long    = (in_byte == cfg.long_profile_code);
		cls.flag_unknown = |(in_byte & ~known);
		cls.flag_digest  = |(in_byte & cfg.digest_flag_mask);
		cls.flag_restr   = |(in_byte & cfg.restriction_flag_mask);
		cls.flag_poss    = |(in_byte & cfg.possession_flag_mask);
	end

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

### rtl/mrp_queue.sv
module mrp_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  mrp_pkg::cls_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output mrp_pkg::cls_item_t pop_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	mrp_pkg::cls_item_t mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/mrp_back.sv
module mrp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  mrp_pkg::cls_item_t item,
	output logic               res_valid,
	input  logic               res_ready,
	output mrp_pkg::result_t   res
);

	typedef struct packed {
		mrp_pkg::phase_t phase;
		logic [15:0]     rem;
		logic            set_rem;
		logic            done;
	} adv_t;

	typedef struct packed {
		mrp_pkg::phase_t phase;
		logic [4:0]      head_index;
		logic [15:0]     rem;
		logic [17:0]     byte_count;
		logic [7:0]      len_hi;
		logic            ver_ok;
		logic            prof_short;
		logic            prof_long;
		logic            fl_digest;
		logic            fl_restr;
		logic            fl_poss;
		logic [7:0]      profile;
		logic [31:0]     chunk;
		logic [63:0]     flen;
		logic [15:0]     total;
		logic [15:0]     data;
		logic [7:0]      flags;
		logic [15:0]     rlen;
		logic [15:0]     plen;
		logic            given;
	} pstate_t;

	pstate_t          st_q;
	pstate_t          st_n;
	logic             out_valid_q;
	mrp_pkg::result_t out_q;
	logic             pop;
	logic             res_load;
	mrp_pkg::status_t res_status;
	adv_t             adv;
	logic [15:0]      rem_dec;
	logic [15:0]      len_full;

	// next section after a given stage, following the flag bits
	function automatic adv_t advance(input logic [1:0] stage, input logic fd,
		input logic fr, input logic fp, input logic sh);
		adv_t a;
		a.phase   = mrp_pkg::PH_DONE;
		a.rem     = '0;
		a.set_rem = 1'b0;
		a.done    = 1'b1;
		if (stage == 2'd0 && fd) begin
			a.phase   = mrp_pkg::PH_DIGEST;
			a.rem     = sh ? mrp_pkg::SHORT_DIGEST : mrp_pkg::LONG_DIGEST;
			a.set_rem = 1'b1;
			a.done    = 1'b0;
		end else if (stage <= 2'd1 && fr) begin
			a.phase = mrp_pkg::PH_RLEN;
			a.done  = 1'b0;
		end else if (stage <= 2'd2 && fp) begin
			a.phase = mrp_pkg::PH_PLEN;
			a.done  = 1'b0;
		end
		return a;
	endfunction

	assign item_ready = !out_valid_q || res_ready;
	assign pop        = item_valid && item_ready;
	assign res_valid  = out_valid_q;
	assign res        = out_q;

	always_comb begin
		st_n       = st_q;
		res_load   = 1'b0;
		res_status = mrp_pkg::ST_OK;
		adv        = advance(2'd3, 1'b0, 1'b0, 1'b0, 1'b0);
		rem_dec    = st_q.rem - 16'd1;
		len_full   = {st_q.len_hi, item.data_byte};
		if (pop && !st_q.given) begin
			st_n.byte_count = st_q.byte_count + 18'd1;
			case (st_q.phase)
				mrp_pkg::PH_HEAD: begin
					st_n.head_index = st_q.head_index + 5'd1;
					if (st_q.head_index == '0) begin
						st_n.ver_ok = item.ver_match;
					end else if (st_q.head_index == 5'd1) begin
						st_n.profile    = item.data_byte;
						st_n.prof_short = item.prof_short;
						st_n.prof_long  = item.prof_long;
					end else if (st_q.head_index <= mrp_pkg::CHUNK_END) begin
						st_n.chunk = {st_q.chunk[23:0], item.data_byte};
					end else if (st_q.head_index <= mrp_pkg::FILE_END) begin
						st_n.flen = {st_q.flen[55:0], item.data_byte};
					end else if (st_q.head_index <= mrp_pkg::TOTAL_END) begin
						st_n.total = {st_q.total[7:0], item.data_byte};
					end else if (st_q.head_index <= mrp_pkg::DATA_END) begin
						st_n.data = {st_q.data[7:0], item.data_byte};
					end else begin
						st_n.flags     = item.data_byte;
						st_n.fl_digest = item.flag_digest;
						st_n.fl_restr  = item.flag_restr;
						st_n.fl_poss   = item.flag_poss;
					end
					if (st_q.head_index == mrp_pkg::HEAD_LAST) begin
						adv = advance(2'd0, item.flag_digest, item.flag_restr,
							item.flag_poss, st_q.prof_short);
						if (!st_q.ver_ok) begin
							res_load   = 1'b1;
							res_status = mrp_pkg::ST_BAD_VER;
						end else if (!st_q.prof_short && !st_q.prof_long) begin
							res_load   = 1'b1;
							res_status = mrp_pkg::ST_BAD_PROF;
						end else if (item.flag_unknown) begin
							res_load   = 1'b1;
							res_status = mrp_pkg::ST_BAD_FLAG;
						end else begin
							st_n.phase = adv.phase;
							if (adv.set_rem) begin
								st_n.rem = adv.rem;
							end
							if (!adv.done) begin
								st_n.head_index = '0;
							end
							res_load = adv.done;
						end
					end
				end
				mrp_pkg::PH_DIGEST, mrp_pkg::PH_RBODY, mrp_pkg::PH_PBODY: begin
					st_n.rem = rem_dec;
					if (st_q.phase == mrp_pkg::PH_DIGEST) begin
						adv = advance(2'd1, st_q.fl_digest, st_q.fl_restr,
							st_q.fl_poss, st_q.prof_short);
					end else if (st_q.phase == mrp_pkg::PH_RBODY) begin
						adv = advance(2'd2, st_q.fl_digest, st_q.fl_restr,
							st_q.fl_poss, st_q.prof_short);
					end else begin
						adv = advance(2'd3, st_q.fl_digest, st_q.fl_restr,
							st_q.fl_poss, st_q.prof_short);
					end
					if (rem_dec == '0) begin
						st_n.phase = adv.phase;
						if (!adv.done) begin
							st_n.head_index = '0;
						end
						res_load = adv.done;
					end
				end
				mrp_pkg::PH_RLEN, mrp_pkg::PH_PLEN: begin
					if (st_q.head_index == '0) begin
						st_n.len_hi     = item.data_byte;
						st_n.head_index = 5'd1;
					end else begin
						st_n.head_index = '0;
						if (st_q.phase == mrp_pkg::PH_RLEN) begin
							st_n.rlen = len_full;
						end else begin
							st_n.plen = len_full;
						end
						if (len_full == '0) begin
							res_load   = 1'b1;
							res_status = mrp_pkg::ST_ZERO_LEN;
						end else begin
							st_n.rem   = len_full;
							st_n.phase = (st_q.phase == mrp_pkg::PH_RLEN)
								? mrp_pkg::PH_RBODY : mrp_pkg::PH_PBODY;
						end
					end
				end
				default: begin
				end
			endcase
			if (!res_load && item.last) begin
				res_load   = 1'b1;
				res_status = mrp_pkg::ST_TRUNCATED;
			end
			st_n.given = res_load;
		end
	end

	// the head phase encodes as zero, so a cleared state is the head phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (pop && item.last) begin
			// the last byte of a buffer starts a fresh parse
			st_q <= '0;
		end else begin
			st_q <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q.status             <= res_status;
			out_q.profile_code       <= st_n.profile;
			out_q.chunk_bytes        <= st_n.chunk;
			out_q.file_length        <= st_n.flen;
			out_q.total_shards       <= st_n.total;
			out_q.data_shards        <= st_n.data;
			out_q.tail_flags         <= st_n.flags;
			out_q.restriction_length <= st_n.rlen;
			out_q.possession_length  <= st_n.plen;
			out_q.consumed_bytes     <= (res_status == mrp_pkg::ST_OK) ? st_n.byte_count : '0;
		end
	end

	a_load_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> pop && !st_q.given)
		else $error("result raised without a fresh byte");

	a_new_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop))
		else $error("result appeared without a popped byte");

	a_consumed_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != mrp_pkg::ST_OK |-> out_q.consumed_bytes == '0)
		else $error("consumed count on a failed record");

	// a head error leaves the index one past the head until the buffer ends
	a_head_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == mrp_pkg::PH_HEAD && !st_q.given
		|-> st_q.head_index < mrp_pkg::HEAD_BYTES)
		else $error("head index ran past the head");

	a_given_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.given && pop && !item.last |=> st_q.given)
		else $error("parse restarted before end of buffer");

endmodule

### rtl/metadata_record_parser.sv
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = end_of_buffer
// m_*     | out | m_tvalid/m_tready  | m_tdata = result fields, status lowest
// cfg_*   | in  | cfg_we             | cfg_index selects register, cfg_data its value
// one byte a cycle sustained unless the result register waits on m_tready; a byte
// taken passes the front register and a queue entry, then the back parse step loads
// the output register, and waits longer while the queue holds bytes
// reset clears the configuration to its defaults and the parse state to the head phase
// the queue lets the front keep taking bytes while the result register waits on m_tready
module metadata_record_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [2:0] status, [10:3] profile_code, [42:11] chunk_bytes, [106:43] file_length,
	// [122:107] total_shards, [138:123] data_shards, [146:139] tail_flags,
	// [162:147] restriction_length, [178:163] possession_length,
	// [196:179] consumed_bytes, [199:197] zero
	output logic [199:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	mrp_pkg::cfg_t      cfg_q;
	logic               f_valid;
	logic               f_ready;
	mrp_pkg::cls_item_t f_item;
	logic               b_valid;
	logic               b_ready;
	mrp_pkg::cls_item_t b_item;
	mrp_pkg::result_t   res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version_code          <= 8'd1;
			cfg_q.short_profile_code    <= 8'd1;
			cfg_q.long_profile_code     <= 8'd2;
			cfg_q.digest_flag_mask      <= 8'd1;
			cfg_q.restriction_flag_mask <= 8'd2;
			cfg_q.possession_flag_mask  <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				mrp_pkg::REG_VERSION:    cfg_q.version_code          <= cfg_data;
				mrp_pkg::REG_SHORT_PROF: cfg_q.short_profile_code    <= cfg_data;
				mrp_pkg::REG_LONG_PROF:  cfg_q.long_profile_code     <= cfg_data;
				mrp_pkg::REG_DIG_MASK:   cfg_q.digest_flag_mask      <= cfg_data;
				mrp_pkg::REG_RES_MASK:   cfg_q.restriction_flag_mask <= cfg_data;
				mrp_pkg::REG_POS_MASK:   cfg_q.possession_flag_mask  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	mrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	mrp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {3'b000, res.consumed_bytes, res.possession_length,
		res.restriction_length, res.tail_flags, res.data_shards, res.total_shards,
		res.file_length, res.chunk_bytes, res.profile_code, res.status};

endmodule

### sim/tb_metadata_record_parser.sv
module tb_metadata_record_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;     // [7:0] data_byte
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [199:0] m_tdata;          // status, profile, chunk, file length, n, k, flags,
	                                // restriction len, possession len, consumed, pad
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [7:0]   cfg_data = '0;

	metadata_record_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #6 clk = ~clk;

	// parser model: configuration copy
	logic [7:0] ver_code = 8'd1;
	logic [7:0] short_code = 8'd1;
	logic [7:0] long_code = 8'd2;
	logic [7:0] dig_mask = 8'd1;
	logic [7:0] res_mask = 8'd2;
	logic [7:0] pos_mask = 8'd4;

	// parser model: parse state
	mrp_pkg::phase_t phase;
	logic [4:0]  head_idx;
	logic [15:0] tail_left;
	logic [17:0] byte_cnt;
	logic [7:0]  len_hi;
	logic [7:0]  prof_q;
	logic [31:0] chunk_q;
	logic [63:0] flen_q;
	logic [15:0] total_q;
	logic [15:0] data_q;
	logic [7:0]  flags_q;
	logic [15:0] rlen_q;
	logic [15:0] plen_q;
	bit          done_q;
	bit          ver_ok_q;

	mrp_pkg::result_t record_reports_due[$];
	int      fail_count = 0;
	int      parsed_bytes = 0;
	bit      tx_gaps = 1'b1;
	bit      rx_stalls = 1'b1;
	int      ready_hold = 0;
	int      ready_roll;

	function automatic void clear_parse();
		phase = mrp_pkg::PH_HEAD;
		head_idx = '0;
		tail_left = '0;
		byte_cnt = '0;
		len_hi = '0;
		prof_q = '0;
		chunk_q = '0;
		flen_q = '0;
		total_q = '0;
		data_q = '0;
		flags_q = '0;
		rlen_q = '0;
		plen_q = '0;
		done_q = 1'b0;
		ver_ok_q = 1'b0;
	endfunction

	// moves to the next announced tail after the given stage; 1 when the record is complete
	function automatic bit next_section(input int stage);
		if (stage == 0 && (flags_q & dig_mask) != 0) begin
			phase = mrp_pkg::PH_DIGEST;
			tail_left = (prof_q == short_code) ? mrp_pkg::SHORT_DIGEST : mrp_pkg::LONG_DIGEST;
			return 1'b0;
		end
		if (stage <= 1 && (flags_q & res_mask) != 0) begin
			phase = mrp_pkg::PH_RLEN;
			head_idx = '0;
			return 1'b0;
		end
		if (stage <= 2 && (flags_q & pos_mask) != 0) begin
			phase = mrp_pkg::PH_PLEN;
			head_idx = '0;
			return 1'b0;
		end
		phase = mrp_pkg::PH_DONE;
		return 1'b1;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, input bit last,
			output mrp_pkg::result_t r);
		bit               have;
		mrp_pkg::status_t st;
		logic [4:0]       idx;
		logic [7:0]       known;
		logic [15:0]      len;
		have = 1'b0;
		st = mrp_pkg::ST_OK;
		r = '0;
		if (done_q) begin
			if (last)
				clear_parse();
			return 1'b0;
		end
		byte_cnt = byte_cnt + 1'b1;
		case (phase)
			mrp_pkg::PH_HEAD: begin
				idx = head_idx;
				if (idx == 0)
					ver_ok_q = (b == ver_code);
				else if (idx == 1)
					prof_q = b;
				else if (idx <= mrp_pkg::CHUNK_END)
					chunk_q = {chunk_q[23:0], b};
				else if (idx <= mrp_pkg::FILE_END)
					flen_q = {flen_q[55:0], b};
				else if (idx <= mrp_pkg::TOTAL_END)
					total_q = {total_q[7:0], b};
				else if (idx <= mrp_pkg::DATA_END)
					data_q = {data_q[7:0], b};
				else
					flags_q = b;
				head_idx = idx + 1'b1;
				if (head_idx == mrp_pkg::HEAD_BYTES) begin
					known = dig_mask | res_mask | pos_mask;
					have = 1'b1;
					if (!ver_ok_q)
						st = mrp_pkg::ST_BAD_VER;
					else if (prof_q != short_code && prof_q != long_code)
						st = mrp_pkg::ST_BAD_PROF;
					else if ((flags_q & ~known) != 0)
						st = mrp_pkg::ST_BAD_FLAG;
					else
						have = next_section(0);
				end
			end
			mrp_pkg::PH_DIGEST: begin
				tail_left = tail_left - 1'b1;
				if (tail_left == 0)
					have = next_section(1);
			end
			mrp_pkg::PH_RLEN, mrp_pkg::PH_PLEN: begin
				if (head_idx == 0) begin
					len_hi = b;
					head_idx = 5'd1;
				end else begin
					len = {len_hi, b};
					head_idx = '0;
					if (phase == mrp_pkg::PH_RLEN)
						rlen_q = len;
					else
						plen_q = len;
					if (len == 0) begin
						have = 1'b1;
						st = mrp_pkg::ST_ZERO_LEN;
					end else begin
						tail_left = len;
						phase = (phase == mrp_pkg::PH_RLEN) ? mrp_pkg::PH_RBODY
							: mrp_pkg::PH_PBODY;
					end
				end
			end
			mrp_pkg::PH_RBODY, mrp_pkg::PH_PBODY: begin
				tail_left = tail_left - 1'b1;
				if (tail_left == 0)
					have = next_section(phase == mrp_pkg::PH_RBODY ? 2 : 3);
			end
			default: ;
		endcase
		if (!have && last) begin
			have = 1'b1;
			st = mrp_pkg::ST_TRUNCATED;
		end
		if (!have)
			return 1'b0;
		r.status = st;
		r.profile_code = prof_q;
		r.chunk_bytes = chunk_q;
		r.file_length = flen_q;
		r.total_shards = total_q;
		r.data_shards = data_q;
		r.tail_flags = flags_q;
		r.restriction_length = rlen_q;
		r.possession_length = plen_q;
		r.consumed_bytes = (st == mrp_pkg::ST_OK) ? byte_cnt : '0;
		done_q = 1'b1;
		if (last)
			clear_parse();
		return 1'b1;
	endfunction

	// result side: random backpressure, short stalls mostly, a long one now and then
	always @(posedge clk) begin
		if (ready_hold > 0)
			ready_hold = ready_hold - 1;
		else if (!rx_stalls)
			m_tready <= 1'b1;
		else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 60) begin
				m_tready <= 1'b1;
				ready_hold = $urandom_range(0, 6);
			end else if (ready_roll < 94) begin
				m_tready <= 1'b0;
				ready_hold = $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b0;
				ready_hold = $urandom_range(10, 40);
			end
		end
	end

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_reports
		mrp_pkg::result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (record_reports_due.size() == 0) begin
				$display("%0t ns: unexpected report, expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = record_reports_due.pop_front();
				compare_field("status", 64'(want.status), 64'(m_tdata[2:0]));
				compare_field("profile_code", 64'(want.profile_code), 64'(m_tdata[10:3]));
				compare_field("chunk_bytes", 64'(want.chunk_bytes), 64'(m_tdata[42:11]));
				compare_field("file_length", want.file_length, m_tdata[106:43]);
				compare_field("total_shards", 64'(want.total_shards),
					64'(m_tdata[122:107]));
				compare_field("data_shards", 64'(want.data_shards), 64'(m_tdata[138:123]));
				compare_field("tail_flags", 64'(want.tail_flags), 64'(m_tdata[146:139]));
				compare_field("restriction_length", 64'(want.restriction_length),
					64'(m_tdata[162:147]));
				compare_field("possession_length", 64'(want.possession_length),
					64'(m_tdata[178:163]));
				compare_field("consumed_bytes", 64'(want.consumed_bytes),
					64'(m_tdata[196:179]));
				compare_field("pad", 64'd0, 64'(m_tdata[199:197]));
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit last);
		int               gap;
		int               roll;
		mrp_pkg::result_t r;
		gap = 0;
		if (tx_gaps) begin
			roll = $urandom_range(0, 99);
			if (roll >= 98)
				gap = $urandom_range(20, 60);
			else if (roll >= 90)
				gap = $urandom_range(4, 10);
			else if (roll >= 65)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!done_q)
			parsed_bytes++;
		if (parse_byte(b, last, r))
			record_reports_due.push_back(r);
	endtask

	task automatic send_buffer(ref logic [7:0] rec[$]);
		for (int i = 0; i < rec.size(); i++)
			send_byte(rec[i], i == rec.size() - 1);
	endtask

	// the block holds no bytes that could still produce a report after this
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (record_reports_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			mrp_pkg::REG_VERSION:    ver_code = val;
			mrp_pkg::REG_SHORT_PROF: short_code = val;
			mrp_pkg::REG_LONG_PROF:  long_code = val;
			mrp_pkg::REG_DIG_MASK:   dig_mask = val;
			mrp_pkg::REG_RES_MASK:   res_mask = val;
			mrp_pkg::REG_POS_MASK:   pos_mask = val;
			default: ;
		endcase
	endtask

	task automatic write_config(input logic [7:0] ver, input logic [7:0] sprof,
			input logic [7:0] lprof, input logic [7:0] dmask, input logic [7:0] rmask,
			input logic [7:0] pmask);
		wait_idle();
		write_reg(mrp_pkg::REG_VERSION, ver);
		write_reg(mrp_pkg::REG_SHORT_PROF, sprof);
		write_reg(mrp_pkg::REG_LONG_PROF, lprof);
		write_reg(mrp_pkg::REG_DIG_MASK, dmask);
		write_reg(mrp_pkg::REG_RES_MASK, rmask);
		write_reg(mrp_pkg::REG_POS_MASK, pmask);
		cfg_we <= 1'b0;
	endtask

	// well-formed record for the current settings; a zero length ends the tail walk
	task automatic build_record(ref logic [7:0] rec[$], input logic [7:0] prof,
			input logic [7:0] flags, input logic [15:0] rlen, input logic [15:0] plen,
			input int fill);
		rec.delete();
		rec.push_back(ver_code);
		rec.push_back(prof);
		for (int i = 0; i < 16; i++)
			rec.push_back(fill == FILL_ZERO ? 8'h00 : fill == FILL_ONES ? 8'hFF : 8'($urandom));
		rec.push_back(flags);
		if ((flags & dig_mask) != 0)
			repeat (prof == short_code ? 32 : 64) rec.push_back(8'($urandom));
		if ((flags & res_mask) != 0) begin
			rec.push_back(rlen[15:8]);
			rec.push_back(rlen[7:0]);
			repeat (rlen) rec.push_back(8'($urandom));
		end
		if ((flags & pos_mask) != 0) begin
			rec.push_back(plen[15:8]);
			rec.push_back(plen[7:0]);
			repeat (plen) rec.push_back(8'($urandom));
		end
	endtask

	function automatic logic [15:0] tail_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return 16'd0;
		if (roll < 85)
			return 16'($urandom_range(1, 8));
		return 16'($urandom_range(9, 40));
	endfunction

	task automatic test_head_decode();
		logic [7:0] rec[$];
		build_record(rec, short_code, 8'h00, 16'd0, 16'd0, FILL_ZERO);
		send_buffer(rec);
		build_record(rec, long_code, 8'h00, 16'd0, 16'd0, FILL_ONES);
		send_buffer(rec);
		// bytes after a complete head are dropped up to the end of the buffer
		build_record(rec, short_code, 8'h00, 16'd0, 16'd0, FILL_RANDOM);
		repeat (4) rec.push_back(8'($urandom));
		send_buffer(rec);
	endtask

	task automatic test_tail_walk();
		logic [7:0] rec[$];
		logic [7:0] all_tails;
		all_tails = dig_mask | res_mask | pos_mask;
		build_record(rec, short_code, all_tails, 16'd3, 16'd2, FILL_RANDOM);
		send_buffer(rec);
		build_record(rec, long_code, all_tails, 16'd1, 16'd1, FILL_RANDOM);
		send_buffer(rec);
		build_record(rec, long_code, dig_mask, 16'd0, 16'd0, FILL_RANDOM);
		rec.push_back(8'hA5);
		send_buffer(rec);
		build_record(rec, short_code, res_mask, 16'h0102, 16'd0, FILL_RANDOM);
		send_buffer(rec);
		build_record(rec, short_code, pos_mask, 16'd0, 16'd5, FILL_RANDOM);
		send_buffer(rec);
		build_record(rec, long_code, res_mask | pos_mask, 16'd2, 16'd7, FILL_RANDOM);
		send_buffer(rec);
	endtask

	task automatic test_error_codes();
		logic [7:0] rec[$];
		build_record(rec, short_code, 8'h00, 16'd0, 16'd0, FILL_RANDOM);
		rec[0] = ver_code ^ 8'h01;
		send_buffer(rec);
		// version is checked before the profile
		build_record(rec, short_code, 8'h00, 16'd0, 16'd0, FILL_RANDOM);
		rec[0] = ver_code ^ 8'h80;
		rec[1] = 8'h03;
		send_buffer(rec);
		// profile is checked before the flags
		build_record(rec, long_code, 8'h00, 16'd0, 16'd0, FILL_ONES);
		rec[1] = 8'hFF;
		rec[18] = 8'hFF;
		send_buffer(rec);
		build_record(rec, short_code, 8'h08, 16'd0, 16'd0, FILL_RANDOM);
		send_buffer(rec);
		build_record(rec, long_code, 8'hFF, 16'd0, 16'd0, FILL_ONES);
		send_buffer(rec);
		build_record(rec, short_code, res_mask | pos_mask, 16'd0, 16'd3, FILL_RANDOM);
		send_buffer(rec);
		// zero length on the final byte still reports the zero length
		build_record(rec, long_code, pos_mask, 16'd0, 16'd0, FILL_RANDOM);
		send_buffer(rec);
	endtask

	task automatic test_truncation();
		logic [7:0] rec[$];
		logic [7:0] all_tails;
		all_tails = dig_mask | res_mask | pos_mask;
		rec.delete();
		rec.push_back(ver_code);
		send_buffer(rec);
		build_record(rec, short_code, 8'h00, 16'd0, 16'd0, FILL_RANDOM);
		rec = rec[0:6];
		send_buffer(rec);
		// a short head is truncated even with a wrong version
		build_record(rec, short_code, 8'h00, 16'd0, 16'd0, FILL_RANDOM);
		rec[0] = ver_code ^ 8'h01;
		rec = rec[0:17];
		send_buffer(rec);
		build_record(rec, short_code, dig_mask, 16'd0, 16'd0, FILL_RANDOM);
		rec = rec[0:18];
		send_buffer(rec);
		build_record(rec, long_code, all_tails, 16'd4, 16'd4, FILL_RANDOM);
		rec = rec[0:28];
		send_buffer(rec);
		build_record(rec, short_code, res_mask, 16'd4, 16'd0, FILL_RANDOM);
		rec = rec[0:19];
		send_buffer(rec);
		build_record(rec, short_code, res_mask, 16'd4, 16'd0, FILL_RANDOM);
		rec = rec[0:22];
		send_buffer(rec);
		build_record(rec, short_code, pos_mask, 16'd0, 16'd6, FILL_RANDOM);
		rec = rec[0:23];
		send_buffer(rec);
	endtask

	// all three tails with the long digest, sent gapless into an always-ready sink
	task automatic test_longest_record();
		logic [7:0] rec[$];
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		build_record(rec, long_code, dig_mask | res_mask | pos_mask, 16'd24, 16'd21,
			FILL_RANDOM);
		send_buffer(rec);
		wait_idle();
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	task automatic send_random_buffer();
		logic [7:0] rec[$];
		int         kind;
		logic [7:0] flags;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			rec.delete();
			repeat ($urandom_range(1, 40)) rec.push_back(8'($urandom));
		end else begin
			flags = 8'($urandom) & (dig_mask | res_mask | pos_mask);
			build_record(rec, $urandom_range(0, 1) ? short_code : long_code, flags,
				tail_len(), tail_len(), FILL_RANDOM);
			if (kind < 20) begin
				case ($urandom_range(0, 2))
					0: rec[0] = rec[0] ^ (8'h01 << $urandom_range(0, 7));
					1: rec[1] = 8'($urandom);
					default: rec[18] = 8'($urandom);
				endcase
			end else if (kind < 32)
				rec = rec[0:$urandom_range(0, rec.size() - 2)];
			else if (kind < 40)
				repeat ($urandom_range(1, 5)) rec.push_back(8'($urandom));
		end
		send_buffer(rec);
	endtask

	task automatic run_random(input int byte_budget);
		int stop_at;
		stop_at = parsed_bytes + byte_budget;
		while (parsed_bytes < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				tx_gaps = !tx_gaps;
			if ($urandom_range(0, 7) == 0)
				rx_stalls = !rx_stalls;
			send_random_buffer();
			if ($urandom_range(0, 29) == 0)
				wait_idle();
		end
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	task automatic test_random_configs();
		write_config(8'h01, 8'h01, 8'h02, 8'h01, 8'h02, 8'h04);
		run_random(40);
		write_config(8'h00, 8'hFF, 8'h00, 8'h80, 8'h40, 8'h01);
		run_random(30);
		// equal profile codes: the short digest wins
		write_config(8'hFF, 8'h55, 8'h55, 8'h10, 8'h20, 8'h40);
		run_random(30);
		// no tails known, any flag bit is unknown
		write_config(8'h3C, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
		run_random(30);
		// every mask covers every bit, so any flag opens all three tails
		write_config(8'h80, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'hFF);
		run_random(30);
		write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
		run_random(40);
	endtask

	initial begin
		clear_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_head_decode();
		test_tail_walk();
		test_error_codes();
		test_truncation();
		test_longest_record();
		test_random_configs();
		wait_idle();
		if (fail_count == 0)
			$display("metadata_record_parser verification clean");
		else
			$display("metadata_record_parser verification failed");
		$finish;
	end

	initial begin
		#30ms;
		$display("%0t ns: timeout with %0d reports outstanding", $time,
			record_reports_due.size());
		$display("metadata_record_parser verification failed");
		$finish;
	end

endmodule
